// File: hdl/rspg_pkg.sv
// Shared constants, control struct and GF(256) helpers for the QR Reed-Solomon parity generator.
package rspg_pkg;

    // Largest supported number of parity bytes (cells in the chain).
    localparam int MAX_PARITY = 32;
    // Width of a cell index.
    localparam int IDX_W = $clog2(MAX_PARITY);
    // Width of a parity count, able to hold MAX_PARITY itself.
    localparam int CNT_W = IDX_W + 1;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1 without its top bit.
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1d;
    // Codeword length of a RS(255, k) code.
    localparam logic [7:0] CODE_LEN = 8'd255;
    // Reset value of the ecc_count register.
    localparam logic [5:0] ECC_RESET = 6'd10;
    // Register index of ecc_count.
    localparam logic REG_ECC_COUNT = 1'b0;

    // Per-cycle commands from the controller to every cell of the chain.
    typedef struct packed {
        logic gen_init;   // load the generator with the constant polynomial 1
        logic gen_step;   // multiply the generator by (x + root)
        logic absorb;     // shift one data byte into the remainder
        logic blk_end;    // the absorbed byte closes the block
        logic clear;      // drop the remainder
        logic out_load;   // capture the new remainder into the unload chain
        logic out_shift;  // move the unload chain one place toward the head
    } cell_ctrl_t;

    // GF(256) multiply, shift-and-add over the eight bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Number of parity bytes actually used for a given register value.
    function automatic logic [CNT_W-1:0] eff_count(input logic [5:0] v);
        logic [CNT_W-1:0] n;
        if (v == 6'd0) begin
            n = CNT_W'(1);
        end else if (int'(v) > MAX_PARITY) begin
            n = CNT_W'(MAX_PARITY);
        end else begin
            n = CNT_W'(v);
        end
        return n;
    endfunction

endpackage

// File: hdl/qr_block_rs_parity_gen.sv
// Top level of the QR block Reed-Solomon parity generator: controller and chain of cells.
//
//   Channel   Direction  Content
//   s_        in         data byte (tdata), last byte of block (tlast)
//   m_        out        parity byte (tdata), last parity (tlast), too long (tuser)
//   APB       in/out     ecc_count at byte address 0
//
// Data bytes are absorbed at one per clock by the LFSR of cells while s_tready is high.
// After a last byte, n parity bytes leave at one per clock from the unload chain while m_tready is high,
// and the data of the next block keeps flowing in; a last byte is taken no earlier
// than the cycle in which the previous block's final parity item leaves.
// After reset or an ecc_count write the generator is rebuilt, one root per cycle, and no item is taken meanwhile.
// Reset is synchronous and active low; m_tready low holds the unload chain in place.
module qr_block_rs_parity_gen (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // Result item stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] parity_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] too_long
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = rspg_pkg::MAX_PARITY;

    logic [5:0]                   ecc_reg, ecc_next;
    logic [rspg_pkg::CNT_W-1:0]   build_left_reg, build_left_next;
    logic [7:0]                   root_reg, root_next;
    logic [7:0]                   cnt_reg, cnt_next;
    logic                         ovf_reg, ovf_next;
    logic [rspg_pkg::CNT_W-1:0]   unload_reg, unload_next;
    logic                         too_long_reg, too_long_next;

    logic [rspg_pkg::CNT_W-1:0]   n_eff;
    logic [rspg_pkg::IDX_W-1:0]   head_idx;
    logic                         cfg_wr;
    logic                         building;
    logic                         in_acc;
    logic                         out_acc;
    logic [7:0]                   fb;
    logic [7:0]                   cnt_sat;
    logic                         ovf_calc;
    rspg_pkg::cell_ctrl_t         ctrl;

    logic [7:0] rem_q [N];
    logic [7:0] gen_q [N];
    logic [7:0] out_q [N];

    // Configuration decode; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rspg_pkg::REG_ECC_COUNT);
    assign prdata = (paddr[2] == rspg_pkg::REG_ECC_COUNT) ? {26'b0, ecc_reg} : 32'h0;

    assign n_eff    = rspg_pkg::eff_count(ecc_reg);
    assign head_idx = rspg_pkg::IDX_W'(n_eff - rspg_pkg::CNT_W'(1));
    assign building = (build_left_reg != '0);

    // Handshakes. A last byte may enter while the final parity item of the
    // previous block is being taken.
    assign s_tready = !building &&
                      ((unload_reg == '0) || !s_tlast ||
                       ((unload_reg == rspg_pkg::CNT_W'(1)) && m_tready));
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = (unload_reg != '0);
    assign out_acc  = m_tvalid && m_tready;

    // Feedback byte taken from the top cell in use.
    assign fb = s_tdata ^ rem_q[head_idx];

    // Block length tracking, saturating at the code length.
    assign cnt_sat  = (cnt_reg == rspg_pkg::CODE_LEN) ? cnt_reg : cnt_reg + 8'd1;
    assign ovf_calc = ovf_reg || (cnt_sat > (rspg_pkg::CODE_LEN - 8'(n_eff)));

    // Commands to the chain.
    always_comb begin
        ctrl           = '0;
        ctrl.gen_init  = cfg_wr;
        ctrl.gen_step  = building && !cfg_wr;
        ctrl.clear     = cfg_wr;
        ctrl.absorb    = in_acc && !cfg_wr;
        ctrl.blk_end   = s_tlast;
        ctrl.out_load  = in_acc && s_tlast && !cfg_wr;
        ctrl.out_shift = out_acc;
    end

    // Controller next state.
    always_comb begin
        ecc_next        = ecc_reg;
        build_left_next = build_left_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        unload_next     = unload_reg;
        too_long_next   = too_long_reg;
        if (cfg_wr) begin
            ecc_next        = pwdata[5:0];
            build_left_next = rspg_pkg::eff_count(pwdata[5:0]);
            root_next       = 8'h01;
            cnt_next        = 8'h00;
            ovf_next        = 1'b0;
        end else begin
            if (building) begin
                build_left_next = build_left_reg - rspg_pkg::CNT_W'(1);
                root_next       = rspg_pkg::gf_mul(root_reg, 8'h02);
            end
            if (out_acc) begin
                unload_next = unload_reg - rspg_pkg::CNT_W'(1);
            end
            if (in_acc) begin
                if (s_tlast) begin
                    cnt_next      = 8'h00;
                    ovf_next      = 1'b0;
                    unload_next   = n_eff;
                    too_long_next = ovf_calc;
                end else begin
                    cnt_next = cnt_sat;
                    ovf_next = ovf_calc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecc_reg        <= rspg_pkg::ECC_RESET;
            build_left_reg <= rspg_pkg::eff_count(rspg_pkg::ECC_RESET);
            root_reg       <= 8'h01;
            cnt_reg        <= 8'h00;
            ovf_reg        <= 1'b0;
            unload_reg     <= '0;
            too_long_reg   <= 1'b0;
        end else begin
            ecc_reg        <= ecc_next;
            build_left_reg <= build_left_next;
            root_reg       <= root_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            unload_reg     <= unload_next;
            too_long_reg   <= too_long_next;
        end
    end

    // Chain of cells; cell k takes its neighbor k-1's values, cell 0 takes zeros.
    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [7:0] prev_rem;
        logic [7:0] prev_gen;
        logic [7:0] prev_out;
        if (k == 0) begin : g_first
            assign prev_rem = 8'h00;
            assign prev_gen = 8'h00;
            assign prev_out = 8'h00;
        end else begin : g_rest
            assign prev_rem = rem_q[k-1];
            assign prev_gen = gen_q[k-1];
            assign prev_out = out_q[k-1];
        end
        rspg_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .gen_init_val ((k == 0) ? 1'b1 : 1'b0),
            .fb           (fb),
            .root         (root_reg),
            .prev_rem     (prev_rem),
            .prev_gen     (prev_gen),
            .prev_out     (prev_out),
            .rem          (rem_q[k]),
            .gen          (gen_q[k]),
            .out_byte     (out_q[k])
        );
    end

    // Result item, taken from the head of the unload chain; the data reads zero for a too-long block.
    assign m_tdata    = too_long_reg ? 8'h00 : out_q[head_idx];
    assign m_tlast    = (unload_reg == rspg_pkg::CNT_W'(1));
    assign m_tuser[0] = too_long_reg;

    // A closing data byte starts a full run of n parity items.
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (m_tvalid && (unload_reg == n_eff)))
        else $error("parity run did not start with n items");

    // The last parity item leaves the output empty unless a new run starts with it.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_tlast && !(in_acc && s_tlast)) |=> !m_tvalid)
        else $error("output still valid after the last parity item");

    // A register write starts a generator rebuild that blocks input.
    a_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (building && !s_tready))
        else $error("no generator rebuild after an ecc_count write");

endmodule

// File: hdl/rspg_cell.sv
// One cell of the chain: a generator coefficient, a remainder byte and an unload byte.
module rspg_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rspg_pkg::cell_ctrl_t ctrl,
    input  logic                 gen_init_val, // 1 for the lowest cell only
    input  logic [7:0]           fb,           // LFSR feedback byte
    input  logic [7:0]           root,         // current root alpha^i during the build
    input  logic [7:0]           prev_rem,
    input  logic [7:0]           prev_gen,
    input  logic [7:0]           prev_out,
    output logic [7:0]           rem,
    output logic [7:0]           gen,
    output logic [7:0]           out_byte
);

    logic [7:0] rem_reg, rem_next;
    logic [7:0] gen_reg, gen_next;
    logic [7:0] out_reg, out_next;
    logic [7:0] rem_calc;

    // Remainder update of the LFSR for one data byte.
    assign rem_calc = prev_rem ^ rspg_pkg::gf_mul(fb, gen_reg);

    // Generator build: g[k] <= g[k-1] + g[k] * root.
    always_comb begin
        gen_next = gen_reg;
        if (ctrl.gen_init) begin
            gen_next = {7'b0, gen_init_val};
        end else if (ctrl.gen_step) begin
            gen_next = prev_gen ^ rspg_pkg::gf_mul(gen_reg, root);
        end
    end

    // Remainder register; it is emptied at the end of every block.
    always_comb begin
        rem_next = rem_reg;
        if (ctrl.clear) begin
            rem_next = 8'h00;
        end else if (ctrl.absorb) begin
            rem_next = ctrl.blk_end ? 8'h00 : rem_calc;
        end
    end

    // Unload chain: catches the final remainder and shifts it out.
    always_comb begin
        out_next = out_reg;
        if (ctrl.out_load) begin
            out_next = rem_calc;
        end else if (ctrl.out_shift) begin
            out_next = prev_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 8'h00;
            gen_reg <= {7'b0, gen_init_val};
        end else begin
            rem_reg <= rem_next;
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign rem      = rem_reg;
    assign gen      = gen_reg;
    assign out_byte = out_reg;

endmodule
